// File: rtl/core/qjt_pkg.sv
// types, constants and helpers shared by the quintic trajectory generator
// no dependencies; used by every module of the block but qjt_div
package qjt_pkg;

    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam logic [23:0] DUR_FLOOR = 24'd655;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

    // register indexes on the configuration port
    localparam logic [2:0] REG_START_Q1 = 3'd0;
    localparam logic [2:0] REG_START_Q2 = 3'd1;
    localparam logic [2:0] REG_END_Q1   = 3'd2;
    localparam logic [2:0] REG_END_Q2   = 3'd3;
    localparam logic [2:0] REG_DURATION = 3'd4;

    // divider quotient lengths
    localparam logic [5:0] QB_TAU = 6'd30;
    localparam logic [5:0] QB_VEL = 6'd24;
    localparam logic [5:0] QB_ACC = 6'd32;

    typedef struct packed {
        logic        rearm;
        logic [15:0] dt;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] pos_q1;
        logic signed [15:0] pos_q2;
        logic signed [23:0] vel_q1;
        logic signed [23:0] vel_q2;
        logic signed [31:0] acc_q1;
        logic signed [31:0] acc_q2;
        logic               done_res;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] start_q1;
        logic signed [15:0] start_q2;
        logic signed [15:0] end_q1;
        logic signed [15:0] end_q2;
        logic [23:0]        move_duration;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TAU,
        ST_TAUW,
        ST_WRAP,
        ST_P2,
        ST_P3,
        ST_P4,
        ST_P5,
        ST_POLY,
        ST_MUL,
        ST_POS,
        ST_VELW,
        ST_ACC,
        ST_ACCW,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       check;
        logic       tau_start;
        logic       tau_cap;
        logic       pow_en;
        logic [1:0] pow_idx;
        logic       poly;
        logic       mul;
        logic       pos;
        logic       vel_cap;
        logic       acc_start;
        logic       acc_cap;
        logic       joint;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic moving;
        logic fin;
        logic div_done;
        logic wrap_ok;
        logic out_full;
    } sts_t;

    function automatic logic signed [15:0] clamp16(logic signed [15:0] v,
                                                    logic signed [15:0] lo,
                                                    logic signed [15:0] hi);
        logic signed [15:0] r;
        r = v;
        if (v < lo)
            r = lo;
        else if (v > hi)
            r = hi;
        return r;
    endfunction

endpackage

// File: rtl/core/quintic_joint_trajectory_generator_core.sv
// top level of the two-joint minimum-jerk trajectory generator
// holds the configuration registers; depends on qjt_pkg, qjt_ctrl, qjt_dp
//
// usage:
//   configuration: APB-style write of start/end angles (Q4.12 rad) and the move
//   duration (2^-16 s) at byte addresses 0, 4, 8, 12, 16. writes take effect at the
//   next tick request with rearm set; pready is tied high, reads return the registers.
//   tick channel: one request per control tick (rearm, dt). tick_ready is high only
//   while the sequencer is idle, so one request is in flight at a time.
//   sample channel: one sample per request (positions, velocities, accelerations,
//   done_res), held in an output register until sample_ready.
// timing:
//   an inactive tick passes the check and output states before sample_valid rises.
//   an active tick waits on the 30-bit tau divide, wraps the angles, forms the
//   powers tau^2 to tau^5 and the polynomials, then per joint multiplies and runs
//   the 24-bit vel and 32-bit acc divides in the shared restoring divider, then
//   loads the output register. the finishing tick skips the tau divide. angle wrap
//   holds the sequencer only when a delta lies more than one turn beyond +-pi.
//   one request is processed at a time; the next request is accepted while the
//   last sample still waits in the output register.
// reset: asynchronous, active low; clears elapsed time, held outputs and the move,
//   sets the duration to 32768. if the sample receiver stalls, the sequencer waits
//   before overwriting the output register.
module quintic_joint_trajectory_generator_core #(
    parameter int JOINT1_LOW      = -12868,
    parameter int JOINT1_HIGH     = 12868,
    parameter int JOINT2_LOW      = -12868,
    parameter int JOINT2_HIGH     = 12868,
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             tick_valid,
    output logic             tick_ready,
    input  qjt_pkg::tick_t   tick,
    output logic             sample_valid,
    input  logic             sample_ready,
    output qjt_pkg::sample_t sample
);
    import qjt_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    cmd_t       cmd;
    sts_t       sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_q1      <= '0;
            cfg_reg.start_q2      <= '0;
            cfg_reg.end_q1        <= '0;
            cfg_reg.end_q2        <= '0;
            cfg_reg.move_duration <= 24'd32768;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_START_Q1: cfg_reg.start_q1      <= pwdata[15:0];
                REG_START_Q2: cfg_reg.start_q2      <= pwdata[15:0];
                REG_END_Q1:   cfg_reg.end_q1        <= pwdata[15:0];
                REG_END_Q2:   cfg_reg.end_q2        <= pwdata[15:0];
                REG_DURATION: cfg_reg.move_duration <= pwdata[23:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_START_Q1: prdata = {16'd0, cfg_reg.start_q1};
            REG_START_Q2: prdata = {16'd0, cfg_reg.start_q2};
            REG_END_Q1:   prdata = {16'd0, cfg_reg.end_q1};
            REG_END_Q2:   prdata = {16'd0, cfg_reg.end_q2};
            REG_DURATION: prdata = {8'd0, cfg_reg.move_duration};
            default:      prdata = '0;
        endcase
    end

    qjt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_ready (tick_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    qjt_dp #(
        .JOINT1_LOW      (JOINT1_LOW),
        .JOINT1_HIGH     (JOINT1_HIGH),
        .JOINT2_LOW      (JOINT2_LOW),
        .JOINT2_HIGH     (JOINT2_HIGH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .tick         (tick),
        .cmd          (cmd),
        .sts          (sts),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample)
    );

endmodule

// File: rtl/core/qjt_div.sv
// restoring divider, one quotient bit per cycle, quotient length chosen per request
// depends on nothing but its ports; used by qjt_dp
module qjt_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [59:0] dividend,
    input  logic [47:0] divisor,
    input  logic [5:0]  qbits,
    output logic        done,
    output logic        ovf,
    output logic [31:0] quotient
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic        ovf_reg, ovf_next;
    logic [47:0] r_reg, r_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] q_reg, q_next;
    logic [47:0] d_reg, d_next;
    logic [59:0] high_part;
    logic        too_big;
    logic [48:0] rs;
    logic        ge;
    logic [48:0] diff;

    always_comb
    begin
        high_part = dividend >> qbits;
        too_big   = high_part >= {12'd0, divisor};
        rs        = {r_reg, low_reg[31]};
        ge        = rs >= {1'b0, d_reg};
        diff      = rs - {1'b0, d_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        r_next    = r_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (start)
        begin
            d_next    = divisor;
            r_next    = high_part[47:0];
            low_next  = dividend[31:0] << (6'd32 - qbits);
            q_next    = '0;
            ovf_next  = too_big;
            cnt_next  = too_big ? 6'd0 : qbits;
            done_next = too_big;
        end
        else if (cnt_reg != 6'd0)
        begin
            r_next    = ge ? diff[47:0] : rs[47:0];
            low_next  = {low_reg[30:0], 1'b0};
            q_next    = {q_reg[30:0], ge};
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign ovf      = ovf_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/core/qjt_ctrl.sv
// sequencer of the trajectory generator: one tick at a time through the datapath
// depends on qjt_pkg (state_t, cmd_t, sts_t)
module qjt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tick_valid,
    output logic          tick_ready,
    input  qjt_pkg::sts_t sts,
    output qjt_pkg::cmd_t cmd
);
    import qjt_pkg::*;

    state_t state_reg, state_next;
    logic   joint_reg, joint_next;

    always_comb
    begin
        state_next = state_reg;
        joint_next = joint_reg;
        case (state_reg)
            ST_IDLE:  if (tick_valid) state_next = ST_CHECK;
            ST_CHECK:
            begin
                joint_next = 1'b0;
                if (!sts.moving)
                    state_next = ST_OUT;
                else if (sts.fin)
                    state_next = ST_WRAP;
                else
                    state_next = ST_TAU;
            end
            ST_TAU:   state_next = ST_TAUW;
            ST_TAUW:  if (sts.div_done) state_next = ST_WRAP;
            ST_WRAP:  if (sts.wrap_ok) state_next = ST_P2;
            ST_P2:    state_next = ST_P3;
            ST_P3:    state_next = ST_P4;
            ST_P4:    state_next = ST_P5;
            ST_P5:    state_next = ST_POLY;
            ST_POLY:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_POS;
            ST_POS:   state_next = ST_VELW;
            ST_VELW:  if (sts.div_done) state_next = ST_ACC;
            ST_ACC:   state_next = ST_ACCW;
            ST_ACCW:
            begin
                if (sts.div_done)
                begin
                    if (joint_reg)
                        state_next = ST_OUT;
                    else
                    begin
                        joint_next = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_OUT:   if (!sts.out_full) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.joint  = joint_reg;
        tick_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                tick_ready = 1'b1;
                cmd.accept = tick_valid;
            end
            ST_CHECK: cmd.check     = 1'b1;
            ST_TAU:   cmd.tau_start = 1'b1;
            ST_TAUW:  cmd.tau_cap   = 1'b1;
            ST_P2:
            begin
                cmd.pow_en  = 1'b1;
                cmd.pow_idx = 2'd0;
            end
            ST_P3:
            begin
                cmd.pow_en  = 1'b1;
                cmd.pow_idx = 2'd1;
            end
            ST_P4:
            begin
                cmd.pow_en  = 1'b1;
                cmd.pow_idx = 2'd2;
            end
            ST_P5:
            begin
                cmd.pow_en  = 1'b1;
                cmd.pow_idx = 2'd3;
            end
            ST_POLY:  cmd.poly      = 1'b1;
            ST_MUL:   cmd.mul       = 1'b1;
            ST_POS:   cmd.pos       = 1'b1;
            ST_VELW:  cmd.vel_cap   = 1'b1;
            ST_ACC:   cmd.acc_start = 1'b1;
            ST_ACCW:  cmd.acc_cap   = 1'b1;
            ST_OUT:   cmd.out_load  = !sts.out_full;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            joint_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            joint_reg <= joint_next;
        end
    end

endmodule

// File: rtl/core/qjt_dp.sv
// datapath: latched move, elapsed time, angle wrap, tau divide, powers, polynomials,
// per-joint scaling with vel and acc divides and saturation, and the output register
// depends on qjt_pkg and qjt_div
module qjt_dp #(
    parameter int JOINT1_LOW      = -12868,
    parameter int JOINT1_HIGH     = 12868,
    parameter int JOINT2_LOW      = -12868,
    parameter int JOINT2_HIGH     = 12868,
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  qjt_pkg::cfg_t    cfg,
    input  qjt_pkg::tick_t   tick,
    input  qjt_pkg::cmd_t    cmd,
    output qjt_pkg::sts_t    sts,
    output logic             sample_valid,
    input  logic             sample_ready,
    output qjt_pkg::sample_t sample
);
    import qjt_pkg::*;

    localparam logic [63:0] ANG_PI_W = ((PI_Q30 >> (29 - ANGLE_FRAC_BITS)) + 64'd1) >> 1;
    localparam logic signed [18:0] ANG_PI  = 19'(ANG_PI_W);
    localparam logic signed [18:0] ANG_2PI = 19'(ANG_PI_W << 1);
    localparam logic signed [15:0] J1_LO = 16'(JOINT1_LOW);
    localparam logic signed [15:0] J1_HI = 16'(JOINT1_HIGH);
    localparam logic signed [15:0] J2_LO = 16'(JOINT2_LOW);
    localparam logic signed [15:0] J2_HI = 16'(JOINT2_HIGH);

    // control state
    logic        moving_reg;
    logic [31:0] elapsed_reg;
    logic        out_valid_reg;

    // move and per-tick payload
    logic signed [15:0] start_reg [2];
    logic [23:0]        dur_reg;
    logic signed [18:0] d_reg [2];
    logic               fin_reg;
    logic               done_reg;
    logic [30:0]        t_reg;
    logic [30:0]        pw_reg [4];
    logic [30:0]        s_reg;
    logic [38:0]        gmag_reg, hmag_reg;
    logic               gneg_reg, hneg_reg;
    logic [47:0]        tsq_reg;
    logic [48:0]        prod_p_reg;
    logic [56:0]        prod_v_reg, prod_a_reg;
    logic               dneg_reg;
    logic signed [15:0] held_pos_reg [2];
    logic signed [23:0] held_vel_reg [2];
    logic signed [31:0] held_acc_reg [2];
    sample_t            sample_reg;

    // accept path
    logic signed [15:0] new_start [2];
    logic signed [15:0] new_end [2];
    logic [23:0]        new_dur;
    logic [23:0]        dur_use;
    logic [32:0]        el_sum;
    logic [31:0]        el_sat;

    always_comb
    begin
        new_start[0] = clamp16(cfg.start_q1, J1_LO, J1_HI);
        new_start[1] = clamp16(cfg.start_q2, J2_LO, J2_HI);
        new_end[0]   = clamp16(cfg.end_q1, J1_LO, J1_HI);
        new_end[1]   = clamp16(cfg.end_q2, J2_LO, J2_HI);
        new_dur      = (cfg.move_duration < DUR_FLOOR) ? DUR_FLOOR : cfg.move_duration;
        dur_use      = tick.rearm ? new_dur : dur_reg;
        el_sum       = {1'b0, (tick.rearm ? 32'd0 : elapsed_reg)} + {17'd0, tick.dt};
        el_sat       = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
    end

    // angle wrap, one step of 2pi per cycle until both deltas are within +-pi
    logic signed [18:0] d_step [2];
    logic               in_range [2];

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            in_range[j] = (d_reg[j] <= ANG_PI) && (d_reg[j] >= -ANG_PI);
            if (d_reg[j] > ANG_PI)
                d_step[j] = d_reg[j] - ANG_2PI;
            else if (d_reg[j] < -ANG_PI)
                d_step[j] = d_reg[j] + ANG_2PI;
            else
                d_step[j] = d_reg[j];
        end
    end

    // divider hookup
    logic        div_start;
    logic [59:0] div_dividend;
    logic [47:0] div_divisor;
    logic [5:0]  div_qbits;
    logic        div_done;
    logic        div_ovf;
    logic [31:0] div_q;
    logic [57:0] vsum;
    logic [59:0] asum;

    always_comb
    begin
        vsum         = {1'b0, prod_v_reg} + 58'({dur_reg, 13'd0});
        asum         = 60'({prod_a_reg, 2'b00}) + 60'(tsq_reg[47:1]);
        div_start    = cmd.tau_start | cmd.pos | cmd.acc_start;
        div_dividend = {6'd0, elapsed_reg[23:0], 30'd0};
        div_divisor  = {24'd0, dur_reg};
        div_qbits    = QB_TAU;
        if (cmd.pos)
        begin
            div_dividend = {16'd0, vsum[57:14]};
            div_qbits    = QB_VEL;
        end
        else if (cmd.acc_start)
        begin
            div_dividend = asum;
            div_divisor  = tsq_reg;
            div_qbits    = QB_ACC;
        end
    end

    qjt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .qbits    (div_qbits),
        .done     (div_done),
        .ovf      (div_ovf),
        .quotient (div_q)
    );

    // powers of tau
    logic [30:0] pow_op;
    logic [61:0] pow_prod;

    always_comb
    begin
        pow_op   = (cmd.pow_idx == 2'd0) ? t_reg : pw_reg[cmd.pow_idx - 2'd1];
        pow_prod = {31'd0, pow_op} * {31'd0, t_reg};
    end

    // quintic and its derivatives
    logic signed [39:0] t1s, t2s, t3s, t4s, t5s;
    logic signed [39:0] s_val, g_val, h_val;

    always_comb
    begin
        t1s   = $signed({9'd0, t_reg});
        t2s   = $signed({9'd0, pw_reg[0]});
        t3s   = $signed({9'd0, pw_reg[1]});
        t4s   = $signed({9'd0, pw_reg[2]});
        t5s   = $signed({9'd0, pw_reg[3]});
        s_val = 40'sd10 * t3s - 40'sd15 * t4s + 40'sd6 * t5s;
        g_val = 40'sd30 * t2s - 40'sd60 * t3s + 40'sd30 * t4s;
        h_val = 40'sd60 * t1s - 40'sd180 * t2s + 40'sd120 * t3s;
    end

    // per-joint scaling
    logic signed [18:0] d_cur;
    logic [17:0]        dmag;
    logic [49:0]        psum;
    logic signed [21:0] pos_full;
    logic signed [15:0] pos_sat;
    logic               vel_over, acc_over;
    logic signed [23:0] vel_sat;
    logic signed [31:0] acc_sat;

    always_comb
    begin
        d_cur    = d_reg[cmd.joint];
        dmag     = d_cur[18] ? 18'(-d_cur) : 18'(d_cur);
        psum     = {1'b0, prod_p_reg} + 50'h0_2000_0000;
        pos_full = dneg_reg ? 22'(start_reg[cmd.joint]) - $signed({2'b00, psum[49:30]})
                            : 22'(start_reg[cmd.joint]) + $signed({2'b00, psum[49:30]});
        if (pos_full > 22'sd32767)
            pos_sat = 16'sh7FFF;
        else if (pos_full < -22'sd32768)
            pos_sat = -16'sh8000;
        else
            pos_sat = pos_full[15:0];

        vel_over = div_ovf | (div_q[31:23] != 9'd0);
        if (dneg_reg ^ gneg_reg)
            vel_sat = vel_over ? 24'sh80_0000 : -$signed(div_q[23:0]);
        else
            vel_sat = vel_over ? 24'sh7F_FFFF : $signed(div_q[23:0]);

        acc_over = div_ovf | div_q[31];
        if (dneg_reg ^ hneg_reg)
            acc_sat = acc_over ? 32'sh8000_0000 : -$signed(div_q);
        else
            acc_sat = acc_over ? 32'sh7FFF_FFFF : $signed(div_q);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg    <= 1'b0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            dur_reg       <= 24'd32768;
            for (int j = 0; j < 2; j++)
            begin
                start_reg[j]    <= '0;
                d_reg[j]        <= '0;
                held_pos_reg[j] <= '0;
                held_vel_reg[j] <= '0;
                held_acc_reg[j] <= '0;
            end
        end
        else
        begin
            if (cmd.accept)
            begin
                if (tick.rearm)
                begin
                    moving_reg <= 1'b1;
                    dur_reg    <= new_dur;
                    for (int j = 0; j < 2; j++)
                    begin
                        start_reg[j] <= new_start[j];
                        d_reg[j]     <= 19'(new_end[j]) - 19'(new_start[j]);
                    end
                end
                if (tick.rearm || moving_reg)
                    elapsed_reg <= el_sat;
            end
            else
            begin
                for (int j = 0; j < 2; j++)
                    d_reg[j] <= d_step[j];
            end
            if (cmd.check && moving_reg && fin_reg)
                moving_reg <= 1'b0;
            if (cmd.pos)
                held_pos_reg[cmd.joint] <= pos_sat;
            if (cmd.vel_cap && div_done)
                held_vel_reg[cmd.joint] <= vel_sat;
            if (cmd.acc_cap && div_done)
                held_acc_reg[cmd.joint] <= acc_sat;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (sample_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            fin_reg <= el_sat >= {8'd0, dur_use};
        if (cmd.check)
        begin
            done_reg <= !moving_reg || fin_reg;
            if (fin_reg)
                t_reg <= ONE_Q30;
        end
        if (cmd.tau_cap && div_done)
            t_reg <= {1'b0, div_q[29:0]};
        if (cmd.pow_en)
            pw_reg[cmd.pow_idx] <= pow_prod[60:30];
        if (cmd.poly)
        begin
            if (s_val < 40'sd0)
                s_reg <= '0;
            else if (s_val > $signed({9'd0, ONE_Q30}))
                s_reg <= ONE_Q30;
            else
                s_reg <= s_val[30:0];
            gneg_reg <= g_val[39];
            hneg_reg <= h_val[39];
            gmag_reg <= g_val[39] ? 39'(-g_val) : g_val[38:0];
            hmag_reg <= h_val[39] ? 39'(-h_val) : h_val[38:0];
            tsq_reg  <= {24'd0, dur_reg} * {24'd0, dur_reg};
        end
        if (cmd.mul)
        begin
            dneg_reg   <= d_cur[18];
            prod_p_reg <= {31'd0, dmag} * {18'd0, s_reg};
            prod_v_reg <= {39'd0, dmag} * {18'd0, gmag_reg};
            prod_a_reg <= {39'd0, dmag} * {18'd0, hmag_reg};
        end
        if (cmd.out_load)
        begin
            sample_reg.pos_q1   <= held_pos_reg[0];
            sample_reg.pos_q2   <= held_pos_reg[1];
            sample_reg.vel_q1   <= held_vel_reg[0];
            sample_reg.vel_q2   <= held_vel_reg[1];
            sample_reg.acc_q1   <= held_acc_reg[0];
            sample_reg.acc_q2   <= held_acc_reg[1];
            sample_reg.done_res <= done_reg;
        end
    end

    assign sts.moving   = moving_reg;
    assign sts.fin      = fin_reg;
    assign sts.div_done = div_done;
    assign sts.wrap_ok  = in_range[0] && in_range[1];
    assign sts.out_full = out_valid_reg && !sample_ready;
    assign sample_valid = out_valid_reg;
    assign sample       = sample_reg;

endmodule

// File: rtl/core/qjt_checker.sv
// port-level checks of the trajectory generator, bound to the top level
// depends on qjt_pkg for the payload types
module qjt_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             tick_valid,
    input logic             tick_ready,
    input logic             sample_valid,
    input logic             sample_ready,
    input qjt_pkg::sample_t sample
);
    // one request in flight: ready drops right after a request is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick_ready stayed high after a request");

    // no sample appears in the cycle right after a request is taken
    a_no_instant_sample: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !$rose(sample_valid))
        else $error("sample came out without processing time");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> sample_valid)
        else $error("sample dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_ready |=> $stable(sample))
        else $error("sample changed while stalled");

endmodule

bind quintic_joint_trajectory_generator_core qjt_checker u_qjt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample)
);
